@@ hdl/egof_pkg.sv @@
package egof_pkg;

	// Fraction bits of the ratio sample/median.
	localparam int RATIO_FRAC = 24;
	// ln(2) in Q0.32.
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	// Number of terms of the exp(-y) series after the constant term.
	localparam logic [3:0] SERIES_TERMS = 4'd13;
	// Above this integer part of the ratio the model CDF is exactly 1.0.
	localparam int K_MAX = 40;
	// Width of the series accumulators.
	localparam int E_BITS = 35;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INS,
		S_INS0,
		S_FIN,
		S_MED_HI,
		S_MED_LO,
		S_CHECK,
		S_RD,
		S_DIVR,
		S_WAITR,
		S_TMUL,
		S_TDIV,
		S_TWAIT,
		S_EFIN,
		S_UDIV,
		S_UWAIT,
		S_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD_FIRST,
		OP_INS_START,
		OP_INS_MOVE,
		OP_INS_PLACE,
		OP_INS_PLACE0,
		OP_OVF_SET,
		OP_MED_RD,
		OP_MED_LAT,
		OP_MED_SUM,
		OP_STAT_INIT,
		OP_RD_SAMPLE,
		OP_DIV_RATIO,
		OP_LAT_RATIO,
		OP_TERM_MUL,
		OP_DIV_TERM,
		OP_TERM_ACC,
		OP_EXP_FIN,
		OP_DIV_U,
		OP_UPD,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic gt;
		logic j_zero;
		logic odd;
		logic m2_zero;
		logic div_done;
		logic jj_last;
		logic i_last;
		logic ovf;
	} sts_t;

endpackage

@@ hdl/egof_div.sv @@
module egof_div #(
	parameter int NUMW = 49,
	parameter int DENW = 25
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic            done,
	output logic [NUMW-1:0] quot
);

	localparam int CNTW = $clog2(NUMW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NUMW-1:0] work_q;
	logic [DENW-1:0] rem_q;
	logic [DENW-1:0] den_q;

	logic [DENW:0]   part;
	logic [DENW:0]   diff;
	logic            ge;
	logic [DENW-1:0] rem_n;

	// One quotient bit per cycle, restoring form.
	always_comb begin
		part  = {rem_q, work_q[NUMW-1]};
		diff  = part - {1'b0, den_q};
		ge    = part >= {1'b0, den_q};
		rem_n = ge ? diff[DENW-1:0] : part[DENW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(NUMW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			work_q <= {work_q[NUMW-2:0], ge};
			rem_q  <= rem_n;
		end
	end

	assign done = done_q;
	assign quot = work_q;

endmodule

@@ hdl/egof_dp.sv @@
module egof_dp #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  egof_pkg::cmd_t         cmd,
	output egof_pkg::sts_t         sts,
	output logic [FRAC_BITS:0]     ks_statistic,
	output logic [FRAC_BITS+1:0]   kuiper_statistic,
	output logic [10:0]            sample_count,
	output logic [1:0]             status
);

	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int RNW  = SAMPLE_BITS + egof_pkg::RATIO_FRAC + 1;
	localparam int UNW  = CW + FRAC_BITS;
	localparam int NUMW = (RNW > UNW) ? RNW : UNW;
	localparam int DENW = (SAMPLE_BITS + 1 > CW) ? SAMPLE_BITS + 1 : CW;
	localparam int DVW  = FRAC_BITS + 3;
	localparam int KW   = NUMW - egof_pkg::RATIO_FRAC;
	localparam int EB   = egof_pkg::E_BITS;
	localparam logic signed [DVW-1:0] ONE = DVW'(1) << FRAC_BITS;
	localparam logic signed [DVW:0]   TWO = (DVW + 1)'(1) << (FRAC_BITS + 1);

	logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic                   we;
	logic [AW-1:0]          wa;
	logic [SAMPLE_BITS-1:0] wd;
	logic [AW-1:0]          ra;

	logic [CW-1:0]          count_q;
	logic                   ovf_q;
	logic [SAMPLE_BITS-1:0] x_q;
	logic [AW-1:0]          j_q;
	logic [SAMPLE_BITS-1:0] a_q;
	logic [SAMPLE_BITS:0]   m2_q;
	logic [CW-1:0]          i_q;
	logic [FRAC_BITS:0]     uprev_q;
	logic signed [DVW-1:0]  hi_q;
	logic signed [DVW-1:0]  lo_q;
	logic signed [DVW-1:0]  best_q;
	logic signed [DVW-1:0]  p_q;
	logic [KW-1:0]          k_q;
	logic [31:0]            y_q;
	logic [31:0]            term_q;
	logic [31:0]            prod_q;
	logic [EB-1:0]          pos_q;
	logic [EB-1:0]          neg_q;
	logic [3:0]             jj_q;
	logic [FRAC_BITS:0]     ks_q;
	logic [FRAC_BITS+1:0]   kp_q;
	logic [10:0]            cnt_out_q;
	logic [1:0]             st_q;

	logic [CW-1:0]          cnt_m1;
	logic [CW-1:0]          half;
	logic [AW-1:0]          half_m1;

	logic                   div_start;
	logic [NUMW-1:0]        div_num;
	logic [DENW-1:0]        div_den;
	logic                   div_done;
	logic [NUMW-1:0]        div_quot;

	logic [55:0]            ymul;
	logic [63:0]            tmul;
	logic [EB-1:0]          e_val;
	logic [6:0]             shv;
	logic [36:0]            rsum;
	logic [36:0]            qv;

	logic signed [DVW-1:0]  d1;
	logic signed [DVW-1:0]  d2;
	logic signed [DVW-1:0]  a1;
	logic signed [DVW-1:0]  a2;
	logic signed [DVW-1:0]  best_n;
	logic signed [DVW-1:0]  hi_n;
	logic signed [DVW-1:0]  lo_n;
	logic signed [DVW:0]    ksum;

	assign cnt_m1  = count_q - 1'b1;
	assign half    = count_q >> 1;
	assign half_m1 = half[AW-1:0] - 1'b1;

	// Memory port selection.
	always_comb begin
		we = 1'b0;
		wa = j_q + 1'b1;
		wd = x_q;
		ra = i_q[AW-1:0];
		unique case (cmd.op)
			egof_pkg::OP_LOAD_FIRST: begin
				we = 1'b1;
				wa = '0;
				wd = sample;
			end
			egof_pkg::OP_INS_START: ra = cnt_m1[AW-1:0];
			egof_pkg::OP_INS_MOVE: begin
				we = 1'b1;
				wd = rd_q;
				ra = j_q - 1'b1;
			end
			egof_pkg::OP_INS_PLACE: we = 1'b1;
			egof_pkg::OP_INS_PLACE0: begin
				we = 1'b1;
				wa = '0;
			end
			egof_pkg::OP_MED_RD:  ra = half[AW-1:0];
			egof_pkg::OP_MED_LAT: ra = half_m1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	// Divider operand selection.
	always_comb begin
		div_start = 1'b0;
		div_num   = NUMW'(prod_q);
		div_den   = DENW'(jj_q);
		unique case (cmd.op)
			egof_pkg::OP_DIV_RATIO: begin
				div_start = 1'b1;
				div_num   = NUMW'({rd_q, (egof_pkg::RATIO_FRAC + 1)'(0)});
				div_den   = DENW'(m2_q);
			end
			egof_pkg::OP_DIV_TERM: div_start = 1'b1;
			egof_pkg::OP_DIV_U: begin
				div_start = 1'b1;
				div_num   = (NUMW'(i_q) + 1'b1) << FRAC_BITS;
				div_den   = DENW'(count_q);
			end
			default: ;
		endcase
	end

	egof_div #(
		.NUMW(NUMW),
		.DENW(DENW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		ymul  = 56'(div_quot[egof_pkg::RATIO_FRAC-1:0]) * 56'(egof_pkg::LN2_Q32);
		tmul  = 64'(term_q) * 64'(y_q);
		e_val = pos_q - neg_q;
		shv   = 7'(k_q[5:0]) + 7'(32 - FRAC_BITS);
		rsum  = 37'(e_val) + (37'd1 << (shv - 7'd1));
		qv    = rsum >> shv;
		if (k_q > KW'(egof_pkg::K_MAX) || shv > 7'd36) begin
			qv = '0;
		end
	end

	// Deviations of the empirical CDF from the model at one sorted sample.
	always_comb begin
		d1     = $signed({2'b00, div_quot[FRAC_BITS:0]}) - p_q;
		d2     = $signed({2'b00, uprev_q}) - p_q;
		a1     = (d1 < 0) ? -d1 : d1;
		a2     = (d2 < 0) ? -d2 : d2;
		best_n = best_q;
		if (a1 > best_n) best_n = a1;
		if (a2 > best_n) best_n = a2;
		hi_n = hi_q;
		if (d1 > hi_n) hi_n = d1;
		if (d2 > hi_n) hi_n = d2;
		lo_n = lo_q;
		if (-d1 > lo_n) lo_n = -d1;
		if (-d2 > lo_n) lo_n = -d2;
		ksum = {hi_q[DVW-1], hi_q} + {lo_q[DVW-1], lo_q};
		if (ksum < 0) ksum = '0;
		if (ksum > TWO) ksum = TWO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (cmd.op)
				egof_pkg::OP_LOAD_FIRST,
				egof_pkg::OP_INS_PLACE,
				egof_pkg::OP_INS_PLACE0: count_q <= count_q + 1'b1;
				egof_pkg::OP_OVF_SET: ovf_q <= 1'b1;
				egof_pkg::OP_OUT_LOAD: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			egof_pkg::OP_INS_START: begin
				x_q <= sample;
				j_q <= cnt_m1[AW-1:0];
			end
			egof_pkg::OP_INS_MOVE: j_q <= j_q - 1'b1;
			egof_pkg::OP_MED_LAT: begin
				a_q  <= rd_q;
				m2_q <= {rd_q, 1'b0};
			end
			egof_pkg::OP_MED_SUM: m2_q <= {1'b0, a_q} + {1'b0, rd_q};
			egof_pkg::OP_STAT_INIT: begin
				i_q     <= '0;
				uprev_q <= '0;
				hi_q    <= -ONE;
				lo_q    <= -ONE;
				best_q  <= '0;
			end
			egof_pkg::OP_LAT_RATIO: begin
				k_q   <= div_quot[NUMW-1:egof_pkg::RATIO_FRAC];
				y_q   <= ymul[55:24];
				pos_q <= EB'(1) << 32;
				neg_q <= '0;
				jj_q  <= 4'd1;
			end
			egof_pkg::OP_TERM_MUL: prod_q <= (jj_q == 4'd1) ? y_q : tmul[63:32];
			egof_pkg::OP_TERM_ACC: begin
				term_q <= div_quot[31:0];
				if (jj_q[0]) begin
					neg_q <= neg_q + EB'(div_quot[31:0]);
				end else begin
					pos_q <= pos_q + EB'(div_quot[31:0]);
				end
				jj_q <= jj_q + 1'b1;
			end
			egof_pkg::OP_EXP_FIN: p_q <= ONE - $signed(DVW'(qv));
			egof_pkg::OP_UPD: begin
				best_q  <= best_n;
				hi_q    <= hi_n;
				lo_q    <= lo_n;
				uprev_q <= div_quot[FRAC_BITS:0];
				i_q     <= i_q + 1'b1;
			end
			egof_pkg::OP_OUT_LOAD: begin
				cnt_out_q <= 11'(count_q);
				st_q      <= cmd.code;
				if (cmd.code == egof_pkg::ST_OK) begin
					ks_q <= best_q[FRAC_BITS:0];
					kp_q <= ksum[FRAC_BITS+1:0];
				end else begin
					ks_q <= '0;
					kp_q <= '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.full     = count_q == CW'(MAX_SAMPLES);
		sts.empty    = count_q == '0;
		sts.gt       = rd_q > x_q;
		sts.j_zero   = j_q == '0;
		sts.odd      = count_q[0];
		sts.m2_zero  = m2_q == '0;
		sts.div_done = div_done;
		sts.jj_last  = jj_q == egof_pkg::SERIES_TERMS;
		sts.i_last   = (i_q + 1'b1) == count_q;
		sts.ovf      = ovf_q;
	end

	assign ks_statistic     = ks_q;
	assign kuiper_statistic = kp_q;
	assign sample_count     = cnt_out_q;
	assign status           = st_q;

endmodule

@@ hdl/egof_ctrl.sv @@
module egof_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last,
	input  logic           out_stall,
	input  egof_pkg::sts_t sts,
	output logic           in_stall,
	output logic           out_valid,
	output egof_pkg::cmd_t cmd
);

	egof_pkg::state_t state_q;
	egof_pkg::state_t state_d;
	logic             last_q;
	logic             last_d;
	logic [1:0]       code_q;
	logic [1:0]       code_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= egof_pkg::S_IDLE;
			last_q      <= 1'b0;
			code_q      <= egof_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
			code_q  <= code_d;
			if (cmd.op == egof_pkg::OP_OUT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		last_d   = last_q;
		code_d   = code_q;
		in_stall = 1'b1;
		cmd.op   = egof_pkg::OP_NONE;
		cmd.code = code_q;
		unique case (state_q)
			egof_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					last_d = last;
					if (sts.full) begin
						cmd.op  = egof_pkg::OP_OVF_SET;
						state_d = last ? egof_pkg::S_FIN : egof_pkg::S_IDLE;
					end else if (sts.empty) begin
						cmd.op  = egof_pkg::OP_LOAD_FIRST;
						state_d = last ? egof_pkg::S_FIN : egof_pkg::S_IDLE;
					end else begin
						cmd.op  = egof_pkg::OP_INS_START;
						state_d = egof_pkg::S_INS;
					end
				end
			end
			egof_pkg::S_INS: begin
				if (sts.gt) begin
					cmd.op = egof_pkg::OP_INS_MOVE;
					if (sts.j_zero) begin
						state_d = egof_pkg::S_INS0;
					end
				end else begin
					cmd.op  = egof_pkg::OP_INS_PLACE;
					state_d = last_q ? egof_pkg::S_FIN : egof_pkg::S_IDLE;
				end
			end
			egof_pkg::S_INS0: begin
				cmd.op  = egof_pkg::OP_INS_PLACE0;
				state_d = last_q ? egof_pkg::S_FIN : egof_pkg::S_IDLE;
			end
			egof_pkg::S_FIN: begin
				if (sts.ovf) begin
					code_d  = egof_pkg::ST_OVF;
					state_d = egof_pkg::S_OUT;
				end else begin
					cmd.op  = egof_pkg::OP_MED_RD;
					state_d = egof_pkg::S_MED_HI;
				end
			end
			egof_pkg::S_MED_HI: begin
				cmd.op  = egof_pkg::OP_MED_LAT;
				state_d = sts.odd ? egof_pkg::S_CHECK : egof_pkg::S_MED_LO;
			end
			egof_pkg::S_MED_LO: begin
				cmd.op  = egof_pkg::OP_MED_SUM;
				state_d = egof_pkg::S_CHECK;
			end
			egof_pkg::S_CHECK: begin
				if (sts.m2_zero) begin
					code_d  = egof_pkg::ST_ZERO;
					state_d = egof_pkg::S_OUT;
				end else begin
					cmd.op  = egof_pkg::OP_STAT_INIT;
					state_d = egof_pkg::S_RD;
				end
			end
			egof_pkg::S_RD: begin
				cmd.op  = egof_pkg::OP_RD_SAMPLE;
				state_d = egof_pkg::S_DIVR;
			end
			egof_pkg::S_DIVR: begin
				cmd.op  = egof_pkg::OP_DIV_RATIO;
				state_d = egof_pkg::S_WAITR;
			end
			egof_pkg::S_WAITR: begin
				if (sts.div_done) begin
					cmd.op  = egof_pkg::OP_LAT_RATIO;
					state_d = egof_pkg::S_TMUL;
				end
			end
			egof_pkg::S_TMUL: begin
				cmd.op  = egof_pkg::OP_TERM_MUL;
				state_d = egof_pkg::S_TDIV;
			end
			egof_pkg::S_TDIV: begin
				cmd.op  = egof_pkg::OP_DIV_TERM;
				state_d = egof_pkg::S_TWAIT;
			end
			egof_pkg::S_TWAIT: begin
				if (sts.div_done) begin
					cmd.op  = egof_pkg::OP_TERM_ACC;
					state_d = sts.jj_last ? egof_pkg::S_EFIN : egof_pkg::S_TMUL;
				end
			end
			egof_pkg::S_EFIN: begin
				cmd.op  = egof_pkg::OP_EXP_FIN;
				state_d = egof_pkg::S_UDIV;
			end
			egof_pkg::S_UDIV: begin
				cmd.op  = egof_pkg::OP_DIV_U;
				state_d = egof_pkg::S_UWAIT;
			end
			egof_pkg::S_UWAIT: begin
				if (sts.div_done) begin
					cmd.op = egof_pkg::OP_UPD;
					if (sts.i_last) begin
						code_d  = egof_pkg::ST_OK;
						state_d = egof_pkg::S_OUT;
					end else begin
						state_d = egof_pkg::S_RD;
					end
				end
			end
			egof_pkg::S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op  = egof_pkg::OP_OUT_LOAD;
					state_d = egof_pkg::S_IDLE;
				end
			end
			default: state_d = egof_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ hdl/exp_goodness_of_fit_test.sv @@
// Loading: a beat is taken and the following beat waits while the sample is
// insertion-sorted into the store, one stored entry per cycle. After the last
// beat, all divisions run on one shared one-bit-per-cycle divider of width
// W = max(SAMPLE_BITS + 25, count width + FRAC_BITS).
// One data set is worked on at a time; the result waits in an output register.
// Reset (arst_n low) empties the store count, clears the overflow flag and drops any result.
module exp_goodness_of_fit_test #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [FRAC_BITS:0]     ks_statistic,
	output logic [FRAC_BITS+1:0]   kuiper_statistic,
	output logic [10:0]            sample_count,
	output logic [1:0]             status
);

	// The controller walks the phases: sorted insertion of each beat, the median,
	// then per sorted sample the ratio division, the exp series and the CDF deviations.
	egof_pkg::cmd_t cmd;
	egof_pkg::sts_t sts;

	egof_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.out_stall(out_stall),
		.sts      (sts),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.cmd      (cmd)
	);

	// The datapath holds the sample store, the shared divider, the multipliers,
	// the running extremes and the result register.
	egof_dp #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample          (sample),
		.cmd             (cmd),
		.sts             (sts),
		.ks_statistic    (ks_statistic),
		.kuiper_statistic(kuiper_statistic),
		.sample_count    (sample_count),
		.status          (status)
	);

endmodule

@@ hdl/egof_checker.sv @@
module egof_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 last,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [FRAC_BITS:0]   ks_statistic,
	input logic [FRAC_BITS+1:0] kuiper_statistic,
	input logic [1:0]           status
);

	localparam logic [FRAC_BITS:0]   KS_MAX = (FRAC_BITS + 1)'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS+1:0] KP_MAX = (FRAC_BITS + 2)'(1) << (FRAC_BITS + 1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ks_statistic)
			&& $stable(kuiper_statistic) && $stable(status))
		else $error("result beat changed while stalled");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall)
		else $error("input taken right after the last beat");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != egof_pkg::ST_OK) |-> ks_statistic == '0
			&& kuiper_statistic == '0)
		else $error("flagged result carries statistics");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ks_statistic <= KS_MAX && kuiper_statistic <= KP_MAX)
		else $error("statistic out of range");

endmodule

bind exp_goodness_of_fit_test egof_checker #(
	.FRAC_BITS(FRAC_BITS)
) u_egof_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.last            (last),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.ks_statistic    (ks_statistic),
	.kuiper_statistic(kuiper_statistic),
	.status          (status)
);

@@ tb/exp_goodness_of_fit_test_test.sv @@
module exp_goodness_of_fit_test_test;

	timeunit 1ns;
	timeprecision 1ps;

	// Each data set is graded after its last beat, and each beat is insertion-sorted
	// while loading. The limit covers the full-capacity set,
	// about 650 random beats at the slowest rate and every stall, several times over.
	localparam longint CYCLE_LIMIT = 64'd6000000;
	localparam int     CAPACITY    = 1024;

	// One result of the block: both statistics, the count used and the status code.
	typedef struct packed {
		logic [16:0] ks;
		logic [17:0] kuiper;
		logic [10:0] count;
		logic [1:0]  code;
	} fit_t;

	// A beat of the directed table. Rows with a typed result give the result
	// that the last beat of the set must produce; the others use the predictor.
	typedef struct packed {
		logic [23:0] value;
		logic        mark;
		logic        typed;
		fit_t        want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [23:0] sample;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [16:0] ks_statistic;
	logic [17:0] kuiper_statistic;
	logic [10:0] sample_count;
	logic [1:0]  status;

	exp_goodness_of_fit_test u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ks_statistic(ks_statistic),
		.kuiper_statistic(kuiper_statistic),
		.sample_count(sample_count),
		.status(status)
	);

	// The predictor keeps its own copy of the sample store and the overflow flag.
	logic [23:0] held[$];
	bit          spilled;
	fit_t        fits_due[$];
	row_t        tags[$];
	int          errors;
	longint      cycles;
	bit          calm;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// The run ends on a stuck handshake or a missing result.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// 2^(-r) for a ratio r in Q.24, rounded to Q.16, by the same truncated series
	// the hardware evaluates. Every intermediate stays below 2^64.
	function automatic longint unsigned exp2_neg_q16(longint unsigned r);
		longint unsigned k, f, y, term, pos, neg, e, sh;
		k = r >> 24;
		f = r & 64'hFF_FFFF;
		if (k > 40)
			return 0;
		y = (f * 64'(egof_pkg::LN2_Q32)) >> 24;
		term = 64'd1 << 32;
		pos = term;
		neg = 0;
		for (int j = 1; j <= 13; j++) begin
			term = ((term * y) >> 32) / 64'(j);
			if (j % 2 == 1)
				neg += term;
			else
				pos += term;
		end
		e = pos - neg;
		sh = k + 16;
		return (e + (64'd1 << (sh - 1))) >> sh;
	endfunction

	// Grades the held data set against an exponential fitted by its median.
	function automatic fit_t grade_set();
		fit_t res;
		logic [23:0] v[$];
		longint unsigned m2, r;
		longint n, p, u0, u1, d1, d2, hi, lo, best, sum;
		res = '0;
		n = held.size();
		res.count = 11'(n);
		if (spilled) begin
			res.code = egof_pkg::ST_OVF;
			return res;
		end
		v = held;
		v.sort();
		if (n % 2 == 0)
			m2 = 64'(v[n/2-1]) + 64'(v[n/2]);
		else
			m2 = 2 * 64'(v[n/2]);
		if (m2 == 0) begin
			res.code = egof_pkg::ST_ZERO;
			return res;
		end
		hi = -65536;
		lo = -65536;
		best = 0;
		for (longint i = 0; i < n; i++) begin
			r = (64'(v[i]) << 25) / m2;
			p = 65536 - longint'(exp2_neg_q16(r));
			u0 = (i << 16) / n;
			u1 = ((i + 1) << 16) / n;
			d1 = u1 - p;
			d2 = u0 - p;
			if (d1 > best) best = d1;
			if (-d1 > best) best = -d1;
			if (d2 > best) best = d2;
			if (-d2 > best) best = -d2;
			if (d1 > hi) hi = d1;
			if (d2 > hi) hi = d2;
			if (-d1 > lo) lo = -d1;
			if (-d2 > lo) lo = -d2;
		end
		sum = hi + lo;
		if (sum < 0) sum = 0;
		if (sum > 131072) sum = 131072;
		res.ks = 17'(best);
		res.kuiper = 18'(sum);
		res.code = egof_pkg::ST_OK;
		return res;
	endfunction

	// Each accepted beat updates the predictor. Its tag, queued when the beat was
	// presented, says whether a typed result replaces the predicted one.
	always @(posedge clk) begin
		row_t tag;
		fit_t guess;
		if (arst_n && in_valid && !in_stall) begin
			tag = tags.pop_front();
			if (held.size() < CAPACITY)
				held.push_back(sample);
			else
				spilled = 1'b1;
			if (last) begin
				guess = grade_set();
				fits_due.push_back(tag.typed ? tag.want : guess);
				held.delete();
				spilled = 1'b0;
			end
		end
	end

	task automatic report(string what, longint want, longint got);
		$display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	// Each accepted result is held against the oldest expectation, field by field.
	always @(posedge clk) begin
		fit_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (fits_due.size() == 0) begin
				report("unexpected result count", 0, sample_count);
			end else begin
				want = fits_due.pop_front();
				if (ks_statistic !== want.ks)
					report("ks_statistic", want.ks, ks_statistic);
				if (kuiper_statistic !== want.kuiper)
					report("kuiper_statistic", want.kuiper, kuiper_statistic);
				if (sample_count !== want.count)
					report("sample_count", want.count, sample_count);
				if (status !== want.code)
					report("status", want.code, status);
			end
		end
	end

	// The receiver stalls mostly in short bursts and sometimes for a long stretch.
	// In calm stretches it starts no new stall, though one already under way runs out.
	int stall_left;
	always @(posedge clk) begin
		int pick;
		pick = $urandom_range(0, 99);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (calm || pick < 65) begin
			out_stall <= 1'b0;
		end else if (pick < 95) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(10, 60);
		end
	end

	// Presents one beat and returns once it has been taken. A gap of idle cycles
	// may come first; most gaps are short and a few are long.
	task automatic send_beat(logic [23:0] value, logic mark, logic typed, fit_t want);
		int gap, pick;
		row_t tag;
		pick = $urandom_range(0, 99);
		if (calm || pick < 60)
			gap = 0;
		else if (pick < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tag.value = value;
		tag.mark = mark;
		tag.typed = typed;
		tag.want = want;
		tags.push_back(tag);
		in_valid <= 1'b1;
		sample <= value;
		last <= mark;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Random content of one beat: full-range values, small values, zeros and
	// repeats, so that spread-out sets, tight sets and zero medians all occur.
	function automatic logic [23:0] pick_value(int flavor);
		case (flavor)
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 255));
			2: return ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom);
			3: return 24'($urandom_range(24'h00F000, 24'h011000));
			default: return ($urandom_range(0, 1) == 0) ? 24'd1 : 24'hFFFFFF;
		endcase
	endfunction

	task automatic wait_drained();
		while (fits_due.size() != 0)
			@(posedge clk);
	endtask

	// Directed beats: zero medians, the extremes of the sample range, a one-beat
	// set with a result that is easy to work out, and a ratio so large that the
	// model CDF is exactly one.
	row_t plan[16] = '{
		'{24'd0,       1'b1, 1'b1, '{17'd0,     18'd0,     11'd1, egof_pkg::ST_ZERO}},
		'{24'hFFFFFF,  1'b1, 1'b1, '{17'd32768, 18'd65536, 11'd1, egof_pkg::ST_OK}},
		'{24'd0,       1'b0, 1'b0, '0},
		'{24'd0,       1'b0, 1'b0, '0},
		'{24'd7,       1'b1, 1'b1, '{17'd0,     18'd0,     11'd3, egof_pkg::ST_ZERO}},
		'{24'hFFFFFF,  1'b0, 1'b0, '0},
		'{24'd0,       1'b1, 1'b0, '0},
		'{24'd1,       1'b0, 1'b0, '0},
		'{24'd1,       1'b0, 1'b0, '0},
		'{24'hFFFFFF,  1'b1, 1'b0, '0},
		'{24'h800000,  1'b0, 1'b0, '0},
		'{24'd1,       1'b0, 1'b0, '0},
		'{24'hFFFFFF,  1'b0, 1'b0, '0},
		'{24'h000001,  1'b0, 1'b0, '0},
		'{24'h555555,  1'b0, 1'b0, '0},
		'{24'hAAAAAA,  1'b1, 1'b0, '0}
	};

	initial begin
		int beats, size, flavor;
		fit_t full;
		errors = 0;
		cycles = 0;
		calm = 1'b0;
		stall_left = 0;
		spilled = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		last = 1'b0;
		out_stall = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_beat(plan[i].value, plan[i].mark, plan[i].typed, plan[i].want);

		// Hold off until every directed result has come back.
		in_valid <= 1'b0;
		@(posedge clk);
		wait_drained();

		// A set one beat larger than the store: the extra beat is dropped and
		// the result carries the overflow code with a full count.
		calm = 1'b1;
		full = '{17'd0, 18'd0, 11'd1024, egof_pkg::ST_OVF};
		for (int i = 0; i <= CAPACITY; i++)
			send_beat(pick_value(i % 5), i == CAPACITY, i == CAPACITY, full);
		calm = 1'b0;

		// Random data sets, mostly small to keep the grading time down, a few
		// of them larger. Some sets run with no idling at all.
		beats = 0;
		while (beats < 650) begin
			calm = ($urandom_range(0, 5) == 0);
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
				: $urandom_range(1, 12);
			flavor = $urandom_range(0, 4);
			for (int i = 0; i < size; i++) begin
				send_beat(pick_value(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
					: flavor), i == size - 1, 1'b0, '0);
			end
			beats += size;
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);

		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && fits_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
